// ----- rtl/fmprc_pkg.sv -----
// Package for the first-match packet rule classifier.
// Holds table sizing, opcode, field and target codes, and the rule and packet records.
// No dependencies; imported by every other file except fmprc_ram.
`timescale 1ns / 1ps
`default_nettype none

package fmprc_pkg;

  // Table sizing
  localparam int MAX_RULES = 64;
  localparam int RULE_AW   = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int LIMIT_W   = $clog2(MAX_RULES + 1);

  // Fixed field widths of the item
  localparam int SLOT_W    = 6;
  localparam int SEL_W     = 3;
  localparam int WORD_W    = 32;
  localparam int IFACE_W   = 16;
  localparam int PROTO_W   = 8;
  localparam int FLAGS_W   = 15;
  localparam int TGT_W     = 3;
  localparam int VERDICT_W = 2;
  localparam int HIDX_W    = 6;
  localparam int POLICY_W  = 2;
  localparam int COUNT_W   = 7;
  localparam int CFG_W     = 7;

  // Stream widths
  localparam int IN_DATA_W  = 152;
  localparam int OUT_DATA_W = 16;

  // Flag word layout
  localparam int FLG_FRAG      = 8;
  localparam int FLG_INV_SRC   = 9;
  localparam int FLG_INV_DST   = 10;
  localparam int FLG_INV_IN    = 11;
  localparam int FLG_INV_OUT   = 12;
  localparam int FLG_INV_PROTO = 13;
  localparam int FLG_INV_FRAG  = 14;

  typedef enum logic [0:0] {
    OP_WRITE    = 1'b0,
    OP_CLASSIFY = 1'b1
  } op_t;

  typedef enum logic [0:0] {
    CFG_POLICY = 1'b0,
    CFG_COUNT  = 1'b1
  } cfg_addr_t;

  typedef enum logic [SEL_W-1:0] {
    FLD_SRC      = 3'd0,
    FLD_SRC_MASK = 3'd1,
    FLD_DST      = 3'd2,
    FLD_DST_MASK = 3'd3,
    FLD_IN_IF    = 3'd4,
    FLD_OUT_IF   = 3'd5,
    FLD_FLAGS    = 3'd6,
    FLD_TARGET   = 3'd7
  } fld_sel_t;

  // Rule targets; codes 4..7 mean no target (walk continues)
  localparam logic [TGT_W-1:0] TGT_DROP   = 3'd0;
  localparam logic [TGT_W-1:0] TGT_ACCEPT = 3'd1;
  localparam logic [TGT_W-1:0] TGT_QUEUE  = 3'd2;
  localparam logic [TGT_W-1:0] TGT_RETURN = 3'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } st_t;

  // One rule as read back from the table
  typedef struct packed {
    logic [WORD_W-1:0]  src;
    logic [WORD_W-1:0]  src_mask;
    logic [WORD_W-1:0]  dst;
    logic [WORD_W-1:0]  dst_mask;
    logic [WORD_W-1:0]  in_if;
    logic [WORD_W-1:0]  out_if;
    logic [FLAGS_W-1:0] flags;
    logic [TGT_W-1:0]   target;
  } rule_t;

  // Packet header fields held during a walk
  typedef struct packed {
    logic [WORD_W-1:0]  src;
    logic [WORD_W-1:0]  dst;
    logic [IFACE_W-1:0] in_if;
    logic [IFACE_W-1:0] out_if;
    logic [PROTO_W-1:0] proto;
    logic               is_frag;
  } pkt_t;

endpackage

`default_nettype wire

// ----- rtl/fmprc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for every rule field store.
`timescale 1ns / 1ps
`default_nettype none

module fmprc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire                                          clk,
  input  wire                                          we,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire  [WIDTH-1:0]                             wdata,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/fmprc_match.sv -----
// Rule compare unit: tests one rule against the held packet header.
// Depends on fmprc_pkg (rule_t, pkt_t, flag layout).
`timescale 1ns / 1ps
`default_nettype none

module fmprc_match (
  input  fmprc_pkg::rule_t rule,
  input  fmprc_pkg::pkt_t  pkt,
  output logic             hit
);

  import fmprc_pkg::*;

  logic               src_miss;
  logic               dst_miss;
  logic               in_miss;
  logic               out_miss;
  logic               proto_fail;
  logic               frag_fail;
  logic [PROTO_W-1:0] rproto;

  assign rproto = rule.flags[PROTO_W-1:0];

  // Address tests
  assign src_miss = (pkt.src & rule.src_mask) != rule.src;
  assign dst_miss = (pkt.dst & rule.dst_mask) != rule.dst;

  // Interface tests: id in the low half, mask in the high half
  assign in_miss  = ((rule.in_if[IFACE_W-1:0] ^ pkt.in_if)
                     & rule.in_if[WORD_W-1:IFACE_W]) != '0;
  assign out_miss = ((rule.out_if[IFACE_W-1:0] ^ pkt.out_if)
                     & rule.out_if[WORD_W-1:IFACE_W]) != '0;

  // Protocol zero matches anything, invert ignored then
  assign proto_fail = (rproto != '0)
                      && ((pkt.proto != rproto) != rule.flags[FLG_INV_PROTO]);

  // Fragment test
  assign frag_fail = (rule.flags[FLG_FRAG] && !pkt.is_frag) != rule.flags[FLG_INV_FRAG];

  assign hit = (src_miss == rule.flags[FLG_INV_SRC])
               && (dst_miss == rule.flags[FLG_INV_DST])
               && (in_miss  == rule.flags[FLG_INV_IN])
               && (out_miss == rule.flags[FLG_INV_OUT])
               && !proto_fail
               && !frag_fail;

endmodule

`default_nettype wire

// ----- rtl/first_match_packet_rule_classifier_unit.sv -----
// First-match packet rule classifier: top level with rule table, walk sequencer
// and output register. Depends on fmprc_pkg, fmprc_ram and fmprc_match.
//
// Usage:
//   Input stream (in_*): in_tuser selects the item kind. A write item stores
//   one field of one rule and gives no result. A classify item walks rules
//   0 .. active_rule_count-1 (capped at MAX_RULES) through a single compare
//   unit, one rule per cycle, reading the rule table memories with one read
//   port each.
//   Output stream (out_*): one result item per classify item.
//   in_tready is low while a walk runs and until its result is loaded into
//   the output register, so no item is taken before a classify finishes.
//   Configuration (cfg_*) must be written only while the block is idle; the
//   block itself does not enforce this.
//   A finished result waits in the output register while the receiver stalls;
//   the next item is accepted meanwhile, and a further walk holds its result
//   until the output register frees.
//   Reset: chain_policy returns to accept and active_rule_count to zero; the
//   rule table is not cleared, rules must be written before they are walked.
`timescale 1ns / 1ps
`default_nettype none

module first_match_packet_rule_classifier_unit (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // in_tdata, low bit up: rule_slot, field_select, field_value, pkt_src_addr,
  // pkt_dst_addr, pkt_in_iface, pkt_out_iface, pkt_proto, pkt_is_ipv4,
  // pkt_is_fragment, zero fill
  input  wire                                   in_tvalid,
  output logic                                  in_tready,
  input  wire  [fmprc_pkg::IN_DATA_W-1:0]       in_tdata,
  input  wire                                   in_tuser,   // op
  // out_tdata, low bit up: verdict, hit_valid, hit_index, zero fill
  output logic                                  out_tvalid,
  input  wire                                   out_tready,
  output logic [fmprc_pkg::OUT_DATA_W-1:0]      out_tdata,
  // configuration write port
  input  wire                                   cfg_we,
  input  wire                                   cfg_addr,
  input  wire  [fmprc_pkg::CFG_W-1:0]           cfg_wdata
);

  import fmprc_pkg::*;

  // Unpacked input fields
  logic [SLOT_W-1:0]  in_slot;
  logic [SEL_W-1:0]   in_sel;
  logic [WORD_W-1:0]  in_value;
  logic               in_is_ipv4;
  pkt_t               in_pkt;

  assign in_slot        = in_tdata[5:0];
  assign in_sel         = in_tdata[8:6];
  assign in_value       = in_tdata[40:9];
  assign in_pkt.src     = in_tdata[72:41];
  assign in_pkt.dst     = in_tdata[104:73];
  assign in_pkt.in_if   = in_tdata[120:105];
  assign in_pkt.out_if  = in_tdata[136:121];
  assign in_pkt.proto   = in_tdata[144:137];
  assign in_is_ipv4     = in_tdata[145];
  assign in_pkt.is_frag = in_tdata[146];

  // State
  st_t                  state_r, state_nxt;
  logic [POLICY_W-1:0]  policy_r;
  logic [COUNT_W-1:0]   count_r;
  logic [LIMIT_W-1:0]   limit_r, limit_nxt;
  logic [RULE_AW-1:0]   eval_idx_r, eval_idx_nxt;
  pkt_t                 pkt_r;
  logic [VERDICT_W-1:0] res_verdict_r, res_verdict_nxt;
  logic                 res_hit_r, res_hit_nxt;
  logic [RULE_AW-1:0]   res_idx_r, res_idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [VERDICT_W-1:0] out_verdict_r;
  logic                 out_hit_r;
  logic [HIDX_W-1:0]    out_idx_r;

  // Control decode
  logic               in_acc;
  logic               acc_write;
  logic               acc_class;
  logic               slot_ok;
  logic [7:0]         fld_we;
  logic [RULE_AW-1:0] waddr;
  logic [RULE_AW-1:0] raddr;
  logic               out_free;
  logic               load_out;

  // Walk decision
  rule_t rule;
  logic  rule_hit;
  logic  decide;
  logic  ret;
  logic  last_rule;
  logic  start_walk;

  assign in_acc    = in_tvalid && in_tready;
  assign acc_write = in_acc && (op_t'(in_tuser) == OP_WRITE);
  assign acc_class = in_acc && (op_t'(in_tuser) == OP_CLASSIFY);
  assign slot_ok   = 32'(in_slot) < MAX_RULES;
  assign waddr     = RULE_AW'(in_slot);
  assign out_free  = !out_valid_r || out_tready;

  // Rule count capped at the table size
  always_comb begin
    if (32'(count_r) > MAX_RULES) begin
      limit_nxt = LIMIT_W'(MAX_RULES);
    end else begin
      limit_nxt = LIMIT_W'(count_r);
    end
  end

  // Field write enables
  always_comb begin
    fld_we = '0;
    if (acc_write && slot_ok) begin
      unique case (fld_sel_t'(in_sel))
        FLD_SRC:      fld_we[0] = 1'b1;
        FLD_SRC_MASK: fld_we[1] = 1'b1;
        FLD_DST:      fld_we[2] = 1'b1;
        FLD_DST_MASK: fld_we[3] = 1'b1;
        FLD_IN_IF:    fld_we[4] = 1'b1;
        FLD_OUT_IF:   fld_we[5] = 1'b1;
        FLD_FLAGS:    fld_we[6] = 1'b1;
        FLD_TARGET:   fld_we[7] = 1'b1;
        default:      fld_we    = '0;
      endcase
    end
  end

  // Read address runs one rule ahead of the compare
  assign raddr = (state_r == ST_WALK) ? eval_idx_r + RULE_AW'(1) : '0;

  // Rule table
  fmprc_ram #(.WIDTH(WORD_W), .DEPTH(MAX_RULES)) u_src_ram (
    .clk(clk), .we(fld_we[0]), .waddr(waddr), .wdata(in_value),
    .raddr(raddr), .rdata(rule.src)
  );
  fmprc_ram #(.WIDTH(WORD_W), .DEPTH(MAX_RULES)) u_src_mask_ram (
    .clk(clk), .we(fld_we[1]), .waddr(waddr), .wdata(in_value),
    .raddr(raddr), .rdata(rule.src_mask)
  );
  fmprc_ram #(.WIDTH(WORD_W), .DEPTH(MAX_RULES)) u_dst_ram (
    .clk(clk), .we(fld_we[2]), .waddr(waddr), .wdata(in_value),
    .raddr(raddr), .rdata(rule.dst)
  );
  fmprc_ram #(.WIDTH(WORD_W), .DEPTH(MAX_RULES)) u_dst_mask_ram (
    .clk(clk), .we(fld_we[3]), .waddr(waddr), .wdata(in_value),
    .raddr(raddr), .rdata(rule.dst_mask)
  );
  fmprc_ram #(.WIDTH(WORD_W), .DEPTH(MAX_RULES)) u_in_if_ram (
    .clk(clk), .we(fld_we[4]), .waddr(waddr), .wdata(in_value),
    .raddr(raddr), .rdata(rule.in_if)
  );
  fmprc_ram #(.WIDTH(WORD_W), .DEPTH(MAX_RULES)) u_out_if_ram (
    .clk(clk), .we(fld_we[5]), .waddr(waddr), .wdata(in_value),
    .raddr(raddr), .rdata(rule.out_if)
  );
  fmprc_ram #(.WIDTH(FLAGS_W), .DEPTH(MAX_RULES)) u_flags_ram (
    .clk(clk), .we(fld_we[6]), .waddr(waddr), .wdata(in_value[FLAGS_W-1:0]),
    .raddr(raddr), .rdata(rule.flags)
  );
  fmprc_ram #(.WIDTH(TGT_W), .DEPTH(MAX_RULES)) u_target_ram (
    .clk(clk), .we(fld_we[7]), .waddr(waddr), .wdata(in_value[TGT_W-1:0]),
    .raddr(raddr), .rdata(rule.target)
  );

  // Shared compare unit
  fmprc_match u_match (
    .rule(rule),
    .pkt (pkt_r),
    .hit (rule_hit)
  );

  assign decide = rule_hit && ((rule.target == TGT_DROP) || (rule.target == TGT_ACCEPT)
                               || (rule.target == TGT_QUEUE));
  assign ret       = rule_hit && (rule.target == TGT_RETURN);
  assign last_rule = (LIMIT_W'(eval_idx_r) + LIMIT_W'(1)) == limit_r;
  assign start_walk = in_is_ipv4 && (limit_nxt != '0);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc_class) begin
          state_nxt = start_walk ? ST_WALK : ST_FINISH;
        end
      end
      ST_WALK: begin
        if (decide || ret || last_rule) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and datapath controls
  always_comb begin
    in_tready       = 1'b0;
    load_out        = 1'b0;
    eval_idx_nxt    = eval_idx_r;
    res_verdict_nxt = res_verdict_r;
    res_hit_nxt     = res_hit_r;
    res_idx_nxt     = res_idx_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready       = 1'b1;
        eval_idx_nxt    = '0;
        res_verdict_nxt = policy_r;
        res_hit_nxt     = 1'b0;
        res_idx_nxt     = '0;
      end
      ST_WALK: begin
        eval_idx_nxt = eval_idx_r + RULE_AW'(1);
        if (decide) begin
          res_verdict_nxt = rule.target[VERDICT_W-1:0];
          res_hit_nxt     = 1'b1;
          res_idx_nxt     = eval_idx_r;
        end
      end
      ST_FINISH: begin
        load_out = out_free;
      end
      default: in_tready = 1'b0;
    endcase
  end

  assign out_valid_nxt = load_out || (out_valid_r && !out_tready);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      policy_r    <= POLICY_W'(1);
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr_t'(cfg_addr))
          CFG_POLICY: policy_r <= cfg_wdata[POLICY_W-1:0];
          CFG_COUNT:  count_r  <= cfg_wdata[COUNT_W-1:0];
          default:    count_r  <= count_r;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    eval_idx_r    <= eval_idx_nxt;
    res_verdict_r <= res_verdict_nxt;
    res_hit_r     <= res_hit_nxt;
    res_idx_r     <= res_idx_nxt;
    if (acc_class) begin
      pkt_r   <= in_pkt;
      limit_r <= limit_nxt;
    end
    if (load_out) begin
      out_verdict_r <= res_verdict_r;
      out_hit_r     <= res_hit_r;
      out_idx_r     <= HIDX_W'(res_idx_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_idx_r, out_hit_r, out_verdict_r};

  // Checks
  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (LIMIT_W'(eval_idx_r) < limit_r))
    else $error("walk index beyond rule limit");

  a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && out_valid_r && !out_tready) |=> (state_r == ST_FINISH))
    else $error("result left finish while output register busy");

  a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && res_hit_r) |-> (LIMIT_W'(res_idx_r) < limit_r))
    else $error("deciding rule outside walked range");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |=> !(state_r == ST_IDLE && $past(decide || ret || last_rule) == 1'b0))
    else $error("walk ended without a decision or table end");

endmodule

`default_nettype wire

// ----- sim/tb_first_match_packet_rule_classifier_unit.sv -----
// Testbench for first_match_packet_rule_classifier_unit: loads the rule table, classifies
// directed and random packets and checks every verdict against a first-match walk of its own.
// Depends on fmprc_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module tb_first_match_packet_rule_classifier_unit;
  import fmprc_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 12;
  localparam int DRAIN_CYCLES  = MAX_RULES + 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 800000;
  localparam int MAX_REPORTS   = 100;

  // Verdict codes
  localparam logic [VERDICT_W-1:0] VERD_DROP   = 2'd0;
  localparam logic [VERDICT_W-1:0] VERD_ACCEPT = 2'd1;
  localparam logic [VERDICT_W-1:0] VERD_QUEUE  = 2'd2;
  localparam logic [VERDICT_W-1:0] VERD_NONE   = 2'd3;

  localparam logic [TGT_W-1:0]   TGT_NONE   = 3'd4;
  localparam logic [PROTO_W-1:0] PROTO_ICMP = 8'd1;
  localparam logic [PROTO_W-1:0] PROTO_TCP  = 8'd6;
  localparam logic [PROTO_W-1:0] PROTO_UDP  = 8'd17;

  // One input item before packing
  typedef struct {
    op_t               op;
    logic [SLOT_W-1:0] slot;
    fld_sel_t          sel;
    logic [WORD_W-1:0] value;
    pkt_t              pkt;
    logic              ipv4;
  } req_t;

  // One classification outcome
  typedef struct packed {
    logic [VERDICT_W-1:0] verdict;
    logic                 hit;
    logic [HIDX_W-1:0]    idx;
  } decision_t;

  // DUT signals
  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   cfg_we = 1'b0;
  logic                   cfg_addr = 1'b0;
  logic [CFG_W-1:0]       cfg_wdata = '0;

  // Shadow of the block state
  rule_t                  tbl [MAX_RULES];
  logic [POLICY_W-1:0]    policy = VERD_ACCEPT;
  logic [COUNT_W-1:0]     rule_count = '0;

  decision_t              decision_q [$];
  int                     mismatch_count = 0;
  int                     cycle_count = 0;
  logic                   tx_idles = 1'b1;
  logic                   rx_idles = 1'b1;
  logic                   hold_off_req = 1'b0;

  first_match_packet_rule_classifier_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic int walk_length();
    return (rule_count > MAX_RULES) ? MAX_RULES : int'(rule_count);
  endfunction

  // All six tests of one rule, each optionally inverted
  function automatic logic rule_hits(int r, pkt_t p);
    rule_t              q;
    logic [FLAGS_W-1:0] fl;
    logic [PROTO_W-1:0] rproto;
    q = tbl[r];
    fl = q.flags;
    rproto = fl[PROTO_W-1:0];
    if (((p.src & q.src_mask) != q.src) != fl[FLG_INV_SRC]) return 1'b0;
    if (((p.dst & q.dst_mask) != q.dst) != fl[FLG_INV_DST]) return 1'b0;
    if ((((q.in_if[15:0] ^ p.in_if) & q.in_if[31:16]) != 16'd0) != fl[FLG_INV_IN])
      return 1'b0;
    if ((((q.out_if[15:0] ^ p.out_if) & q.out_if[31:16]) != 16'd0) != fl[FLG_INV_OUT])
      return 1'b0;
    // protocol zero is a wildcard, its invert bit ignored
    if (rproto != '0 && ((p.proto != rproto) != fl[FLG_INV_PROTO])) return 1'b0;
    if ((fl[FLG_FRAG] && !p.is_frag) != fl[FLG_INV_FRAG]) return 1'b0;
    return 1'b1;
  endfunction

  // First-match walk; RETURN or end of table falls back to the chain policy
  function automatic decision_t classify_packet(pkt_t p, logic ipv4);
    decision_t res;
    int        n;
    res.verdict = policy;
    res.hit = 1'b0;
    res.idx = '0;
    n = walk_length();
    if (ipv4) begin
      for (int r = 0; r < n; r++) begin
        if (rule_hits(r, p)) begin
          if (tbl[r].target == TGT_RETURN) break;
          if (tbl[r].target == TGT_DROP || tbl[r].target == TGT_ACCEPT ||
              tbl[r].target == TGT_QUEUE) begin
            res.verdict = tbl[r].target[VERDICT_W-1:0];
            res.hit = 1'b1;
            res.idx = HIDX_W'(r);
            break;
          end
        end
      end
    end
    return res;
  endfunction

  function automatic void store_rule_field(req_t it);
    case (it.sel)
      FLD_SRC:      tbl[it.slot].src      = it.value;
      FLD_SRC_MASK: tbl[it.slot].src_mask = it.value;
      FLD_DST:      tbl[it.slot].dst      = it.value;
      FLD_DST_MASK: tbl[it.slot].dst_mask = it.value;
      FLD_IN_IF:    tbl[it.slot].in_if    = it.value;
      FLD_OUT_IF:   tbl[it.slot].out_if   = it.value;
      FLD_FLAGS:    tbl[it.slot].flags    = it.value[FLAGS_W-1:0];
      default:      tbl[it.slot].target   = it.value[TGT_W-1:0];
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Item builders
  // ---------------------------------------------------------------------------

  function automatic pkt_t random_packet();
    pkt_t p;
    p = {$urandom, $urandom, 16'($urandom), 16'($urandom), 8'($urandom), 1'($urandom)};
    return p;
  endfunction

  function automatic req_t write_req(int slot, fld_sel_t sel, logic [WORD_W-1:0] value);
    req_t it;
    it.op = OP_WRITE;
    it.slot = SLOT_W'(slot);
    it.sel = sel;
    it.value = value;
    it.pkt = random_packet();
    it.ipv4 = 1'($urandom);
    return it;
  endfunction

  function automatic req_t classify_req(pkt_t p, logic ipv4);
    req_t it;
    it.op = OP_CLASSIFY;
    it.slot = SLOT_W'($urandom);
    it.sel = fld_sel_t'($urandom_range(0, 7));
    it.value = $urandom;
    it.pkt = p;
    it.ipv4 = ipv4;
    return it;
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_item(req_t it);
    return {5'b0, it.pkt.is_frag, it.ipv4, it.pkt.proto, it.pkt.out_if, it.pkt.in_if,
            it.pkt.dst, it.pkt.src, it.value, it.sel, it.slot};
  endfunction

  function automatic logic [WORD_W-1:0] prefix_mask(int len);
    return ~(32'hFFFF_FFFF >> len);
  endfunction

  function automatic logic [IFACE_W-1:0] random_iface_mask();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return ~(16'hFFFF >> $urandom_range(0, 16));
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly well-formed rules: prefix masks, common protocols, rare inverts
  function automatic rule_t random_rule();
    rule_t              q;
    logic [5:0]         inv;
    logic [PROTO_W-1:0] proto;
    q.src_mask = prefix_mask($urandom_range(0, 32));
    q.src = ($urandom_range(0, 7) == 0) ? $urandom : ($urandom & q.src_mask);
    q.dst_mask = prefix_mask($urandom_range(0, 32));
    q.dst = ($urandom_range(0, 7) == 0) ? $urandom : ($urandom & q.dst_mask);
    q.in_if = {random_iface_mask(), 16'($urandom)};
    q.out_if = {random_iface_mask(), 16'($urandom)};
    case ($urandom_range(0, 7))
      0:       proto = PROTO_TCP;
      1:       proto = PROTO_UDP;
      2:       proto = PROTO_ICMP;
      3:       proto = 8'($urandom);
      default: proto = '0;
    endcase
    for (int k = 0; k < 6; k++) inv[k] = ($urandom_range(0, 7) == 0);
    q.flags = {inv, 1'($urandom_range(0, 3) == 0), proto};
    q.target = TGT_W'($urandom_range(0, 7));
    return q;
  endfunction

  // Packet that satisfies the masked fields of rule r, sometimes with one address bit off
  function automatic pkt_t packet_near_rule(int r);
    pkt_t  p;
    rule_t q;
    int    b;
    q = tbl[r];
    p.src = (q.src & q.src_mask) | ($urandom & ~q.src_mask);
    p.dst = (q.dst & q.dst_mask) | ($urandom & ~q.dst_mask);
    p.in_if = (q.in_if[15:0] & q.in_if[31:16]) | (16'($urandom) & ~q.in_if[31:16]);
    p.out_if = (q.out_if[15:0] & q.out_if[31:16]) | (16'($urandom) & ~q.out_if[31:16]);
    p.proto = ($urandom_range(0, 3) == 0) ? 8'($urandom) : q.flags[PROTO_W-1:0];
    p.is_frag = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 3) == 0) begin
      b = $urandom_range(0, 31);
      if ($urandom_range(0, 1) == 1) p.src[b] = ~p.src[b];
      else p.dst[b] = ~p.dst[b];
    end
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one item, wait for acceptance, then update the shadow state
  task automatic send_item(input req_t it);
    if (tx_idles && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= it.op;
    in_tdata <= pack_item(it);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (it.op == OP_WRITE) store_rule_field(it);
    else decision_q.push_back(classify_packet(it.pkt, it.ipv4));
  endtask

  // Eight field writes; flags and target carry junk in their unused upper bits
  task automatic load_rule(input int slot, input rule_t q);
    send_item(write_req(slot, FLD_SRC, q.src));
    send_item(write_req(slot, FLD_SRC_MASK, q.src_mask));
    send_item(write_req(slot, FLD_DST, q.dst));
    send_item(write_req(slot, FLD_DST_MASK, q.dst_mask));
    send_item(write_req(slot, FLD_IN_IF, q.in_if));
    send_item(write_req(slot, FLD_OUT_IF, q.out_if));
    send_item(write_req(slot, FLD_FLAGS, {17'($urandom), q.flags}));
    send_item(write_req(slot, FLD_TARGET, {29'($urandom), q.target}));
  endtask

  // Register write once the block has gone quiet
  task automatic write_config(input cfg_addr_t idx, input logic [CFG_W-1:0] value);
    in_tvalid <= 1'b0;
    while (decision_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_POLICY) policy = value[POLICY_W-1:0];
    else rule_count = value;
  endtask

  task automatic set_chain(input logic [POLICY_W-1:0] pol, input int count);
    write_config(CFG_POLICY, CFG_W'(pol));
    write_config(CFG_COUNT, CFG_W'(count));
  endtask

  task automatic send_random_classify();
    int n;
    n = walk_length();
    if ($urandom_range(0, 4) == 0 || n == 0)
      send_item(classify_req(random_packet(), $urandom_range(0, 7) != 0));
    else
      send_item(classify_req(packet_near_rule($urandom_range(0, n - 1)),
                             $urandom_range(0, 7) != 0));
  endtask

  // ---------------------------------------------------------------------------
  // Result sink with random stalls and one long hold-off
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    int gap;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (rx_idles && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        gap = $urandom_range(1, 13);
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int want, input int got);
    if (mismatch_count < MAX_REPORTS)
      $display("[%0t] mismatch %s: expected %0d, got %0d", $realtime, what, want, got);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_results
    decision_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (decision_q.size() == 0) begin
        report_mismatch("unexpected result item", -1, int'(out_tdata));
      end else begin
        want = decision_q.pop_front();
        if (out_tdata[1:0] !== want.verdict)
          report_mismatch("verdict", want.verdict, out_tdata[1:0]);
        if (out_tdata[2] !== want.hit)
          report_mismatch("hit_valid", want.hit, out_tdata[2]);
        if (out_tdata[8:3] !== want.idx)
          report_mismatch("hit_index", want.idx, out_tdata[8:3]);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty table: the policy alone decides
  task automatic test_empty_table();
    set_chain(VERD_NONE, 0);
    send_item(classify_req({32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1},
                           1'b1));
    send_item(classify_req('0, 1'b1));
  endtask

  // Every slot gets a full rule so any walk length is legal afterwards
  task automatic test_table_load();
    for (int s = 0; s < MAX_RULES; s++) load_rule(s, random_rule());
  endtask

  task automatic test_directed_rules();
    // wildcard rule with no target: the walk continues past it
    load_rule(0, {32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 15'h0, TGT_NONE});
    // 10/8 from ifaces 0x001x, TCP only
    load_rule(1, {32'h0A00_0000, 32'hFF00_0000, 32'h0, 32'h0, 32'hFFF0_0010, 32'h0,
                  {7'h0, PROTO_TCP}, TGT_ACCEPT});
    // any source but the broadcast, UDP: RETURN to the policy
    load_rule(2, {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0,
                  (15'd1 << FLG_INV_SRC) | {7'h0, PROTO_UDP}, TGT_RETURN});
    // fragments only
    load_rule(3, {32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                  15'd1 << FLG_FRAG, TGT_QUEUE});
    // fragment invert with frag clear: never matches
    load_rule(4, {32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                  15'd1 << FLG_INV_FRAG, TGT_DROP});
    // dst not zero and egress not 0x0bad; proto invert with proto zero is inert
    load_rule(5, {32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_0BAD,
                  (15'd1 << FLG_INV_DST) | (15'd1 << FLG_INV_OUT) |
                  (15'd1 << FLG_INV_PROTO), TGT_DROP});

    set_chain(VERD_DROP, 6);
    send_item(classify_req({32'h0A01_0203, 32'h0102_0304, 16'h0015, 16'h0001, PROTO_TCP,
                            1'b0}, 1'b1));
    send_item(classify_req({32'h0A01_0203, 32'h0102_0304, 16'h0015, 16'h0001, PROTO_UDP,
                            1'b0}, 1'b1));
    send_item(classify_req({32'hFFFF_FFFF, 32'hC0A8_0001, 16'h0015, 16'h0001, PROTO_UDP,
                            1'b1}, 1'b1));
    send_item(classify_req({32'hFFFF_FFFF, 32'hC0A8_0001, 16'h0015, 16'h0001, PROTO_UDP,
                            1'b0}, 1'b1));
    send_item(classify_req({32'hFFFF_FFFF, 32'h0, 16'h0015, 16'h0BAD, PROTO_ICMP, 1'b0},
                           1'b1));
    // non-IPv4 copy of the first packet
    send_item(classify_req({32'h0A01_0203, 32'h0102_0304, 16'h0015, 16'h0001, PROTO_TCP,
                            1'b0}, 1'b0));
    send_item(classify_req('0, 1'b1));
    send_item(classify_req({32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1},
                           1'b1));

    // count above the table size walks the whole table
    set_chain(VERD_QUEUE, 127);
    send_item(classify_req({32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1},
                           1'b1));
    send_item(classify_req({32'hFFFF_FFFF, 32'h0, 16'h0015, 16'h0BAD, PROTO_ICMP, 1'b0},
                           1'b1));
    send_item(classify_req('0, 1'b1));
    write_config(CFG_COUNT, CFG_W'(MAX_RULES));
    send_item(classify_req({32'hFFFF_FFFF, 32'h0, 16'h0015, 16'h0BAD, PROTO_ICMP, 1'b0},
                           1'b1));

    set_chain(VERD_ACCEPT, 1);
    send_item(classify_req({32'h0A01_0203, 32'h0102_0304, 16'h0015, 16'h0001, PROTO_TCP,
                            1'b0}, 1'b1));
    send_item(classify_req('0, 1'b0));
  endtask

  // Phases of mostly rule-shaped packets with rule rewrites mixed in
  task automatic test_random_phases();
    int unsigned counts   [9] = '{64, 1, 127, 0, 65, 8, 33, 2, 64};
    int unsigned policies [9] = '{0, 3, 1, 2, 3, 0, 2, 1, 3};
    int          roll;
    for (int ph = 0; ph < 9; ph++) begin
      set_chain(POLICY_W'(policies[ph]), counts[ph]);
      repeat (70) begin
        roll = $urandom_range(0, 9);
        if (roll == 0)
          send_item(write_req($urandom_range(0, MAX_RULES - 1),
                              fld_sel_t'($urandom_range(0, 7)), $urandom));
        else if (roll == 1)
          load_rule($urandom_range(0, MAX_RULES - 1), random_rule());
        else
          send_random_classify();
      end
    end
  endtask

  // Receiver holds off while classify items keep coming, filling the block
  task automatic test_output_backpressure();
    set_chain(VERD_NONE, 16);
    hold_off_req = 1'b1;
    repeat (12) send_random_classify();
  endtask

  // Back-to-back traffic with no idling on either side
  task automatic test_full_rate_tail();
    set_chain(POLICY_W'($urandom_range(0, 3)), MAX_RULES);
    tx_idles = 1'b0;
    rx_idles = 1'b0;
    repeat (100) send_random_classify();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_table_load();
    test_directed_rules();
    test_random_phases();
    test_output_backpressure();
    test_full_rate_tail();

    in_tvalid <= 1'b0;
    while (decision_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
